// ===== src/trpc_pkg.sv =====
`default_nettype none

package trpc_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned TGT_W    = 8;
  localparam int unsigned MEAS_W   = 12;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned HDUTY_W  = 10;
  localparam int unsigned GAIN_W   = 32;
  localparam int unsigned LIMIT_W  = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ERR_W    = 13;
  localparam int unsigned INTEG_W  = 22;
  localparam int unsigned DERIV_W  = 14;
  localparam int unsigned PERR_W   = GAIN_W + ERR_W;
  localparam int unsigned PINT_W   = GAIN_W + INTEG_W;
  localparam int unsigned PDER_W   = GAIN_W + DERIV_W;
  localparam int unsigned SUM_W    = 56;
  localparam int unsigned FRAC_W   = 20;

  localparam logic [OP_W-1:0] OP_POLL    = 3'd0;
  localparam logic [OP_W-1:0] OP_RUN     = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
  localparam logic [OP_W-1:0] OP_FAN_ON  = 3'd3;
  localparam logic [OP_W-1:0] OP_FAN_OFF = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 2'd3;

  localparam logic [TGT_W-1:0]          TARGET_RST      = 8'd25;
  localparam logic [LIMIT_W-1:0]        INTEG_LIMIT_RST = 20'd41600;
  localparam logic signed [ERR_W-1:0]   FAN_ERR_LIMIT   = -13'sd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_READY = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_FAN   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DUTY_HOLD = 2'd0,
    DUTY_ZERO = 2'd1,
    DUTY_PID  = 2'd2
  } duty_act_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [TGT_W-1:0]  target_temp;
    logic [MEAS_W-1:0] measured_temp;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [HDUTY_W-1:0] heater_duty;
    logic               heater_enable;
    logic               fan_drive;
    logic               fault_flag;
  } out_item_t;

  typedef struct packed {
    mode_e mode;
    logic  pwm;
    logic  fan;
    logic  fault;
  } status_t;

  typedef struct packed {
    status_t                   st;
    duty_act_e                 act;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } pid_t;

  typedef struct packed {
    status_t                 st;
    duty_act_e               act;
    logic signed [SUM_W-1:0] sum;
  } mac_t;

endpackage

`default_nettype wire

// ===== src/thermal_pid_run_controller.sv =====
// Throughput: one item per cycle while the output is not stalled; the stages
// are input register, PID state, gain multiplies, three-term sum and the
// saturating output register.
// Reset: asynchronous, active low; clears the mode machine, the PID state,
// the pipeline valid bits and loads the configuration registers with defaults.
`default_nettype none

// Thermal run controller. The item in the input register is decoded by the
// mode machine, which also computes the error, the clamped integral and the
// derivative and commits that state as the item moves into the PID stage.
// Because the heater duty is never fed back into the loop, the multiplies
// and the sum can run behind the state update without limiting the rate.
// Each stage carries a duty action (hold, zero or PID result) so that the
// output register applies the duty exactly in item order.
module thermal_pid_run_controller #(
  parameter int unsigned DUTY_MAX = 1023
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // item input
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire trpc_pkg::in_item_t                  in_item_i,
  // result output
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output trpc_pkg::out_item_t                      out_item_o,
  // configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [trpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [trpc_pkg::GAIN_W-1:0]         cfg_data_i
);

  localparam int unsigned DUTY_BITS = $clog2(DUTY_MAX + 1);
  localparam int unsigned DUTY_W    = (DUTY_BITS < trpc_pkg::HDUTY_W) ? trpc_pkg::HDUTY_W
                                                                      : DUTY_BITS;
  localparam int unsigned SHIFT_W   = trpc_pkg::SUM_W - trpc_pkg::FRAC_W;

  // Configuration registers. Writes are always taken.
  logic signed [trpc_pkg::GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [trpc_pkg::LIMIT_W-1:0]       integ_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= '0;
      integ_gain_q  <= '0;
      deriv_gain_q  <= '0;
      integ_limit_q <= trpc_pkg::INTEG_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        trpc_pkg::CFG_PROP_GAIN:   prop_gain_q   <= $signed(cfg_data_i);
        trpc_pkg::CFG_INTEG_GAIN:  integ_gain_q  <= $signed(cfg_data_i);
        trpc_pkg::CFG_DERIV_GAIN:  deriv_gain_q  <= $signed(cfg_data_i);
        trpc_pkg::CFG_INTEG_LIMIT: integ_limit_q <= cfg_data_i[trpc_pkg::LIMIT_W-1:0];
        default: begin
          integ_limit_q <= integ_limit_q;
        end
      endcase
    end
  end

  // Pipeline valid bits. A stage takes a new item when it is empty or its
  // item moves on in the same cycle, so bubbles are squeezed out and items
  // keep entering while a finished result waits at the output.
  logic v_in_q, v_pid_q, v_mul_q, v_sum_q, v_out_q;
  logic rdy_in, rdy_pid, rdy_mul, rdy_sum, rdy_out;

  assign rdy_out = !v_out_q || !out_stall_i;
  assign rdy_sum = !v_sum_q || rdy_out;
  assign rdy_mul = !v_mul_q || rdy_sum;
  assign rdy_pid = !v_pid_q || rdy_mul;
  assign rdy_in  = !v_in_q  || rdy_pid;

  assign in_stall_o  = !rdy_in;
  assign out_valid_o = v_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_pid_q <= 1'b0;
      v_mul_q <= 1'b0;
      v_sum_q <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      if (rdy_in)  v_in_q  <= in_valid_i;
      if (rdy_pid) v_pid_q <= v_in_q;
      if (rdy_mul) v_mul_q <= v_pid_q;
      if (rdy_sum) v_sum_q <= v_mul_q;
      if (rdy_out) v_out_q <= v_sum_q;
    end
  end

  // Input register.
  trpc_pkg::in_item_t in_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_in) begin
      in_q <= in_item_i;
    end
  end

  // Mode machine and PID state.
  trpc_pkg::pid_t pid;

  trpc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .commit_i      (v_in_q && rdy_pid),
    .item_i        (in_q),
    .integ_limit_i (integ_limit_q),
    .pid_o         (pid)
  );

  // Gain multiplies and sum.
  trpc_pkg::mac_t mac;

  trpc_mac u_mac (
    .clk_i        (clk_i),
    .load_mul_i   (v_pid_q && rdy_mul),
    .load_sum_i   (v_mul_q && rdy_sum),
    .pid_i        (pid),
    .prop_gain_i  (prop_gain_q),
    .integ_gain_i (integ_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .mac_o        (mac)
  );

  // Output register. A negative sum gives zero duty, otherwise the sum is
  // scaled down by 2^20 and saturated at DUTY_MAX. The duty register keeps
  // its value for items that do not touch the heater.
  logic [SHIFT_W-1:0]      shifted;
  logic [DUTY_W-1:0]       duty_pid, duty_q, duty_d;
  trpc_pkg::status_t       st_q;
  logic                    load_out;

  assign load_out = v_sum_q && rdy_out;
  assign shifted  = mac.sum[trpc_pkg::SUM_W-1:trpc_pkg::FRAC_W];

  always_comb begin
    if (mac.sum[trpc_pkg::SUM_W-1]) begin
      duty_pid = '0;
    end else if (shifted > SHIFT_W'(DUTY_MAX)) begin
      duty_pid = DUTY_W'(DUTY_MAX);
    end else begin
      duty_pid = DUTY_W'(shifted);
    end
    case (mac.act)
      trpc_pkg::DUTY_ZERO: duty_d = '0;
      trpc_pkg::DUTY_PID:  duty_d = duty_pid;
      default:             duty_d = duty_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
    end else if (load_out) begin
      duty_q <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      st_q <= mac.st;
    end
  end

  assign out_item_o.mode          = st_q.mode;
  assign out_item_o.heater_duty   = duty_q[trpc_pkg::HDUTY_W-1:0];
  assign out_item_o.heater_enable = st_q.pwm;
  assign out_item_o.fan_drive     = st_q.fan;
  assign out_item_o.fault_flag    = st_q.fault;

`ifndef ASSERT_OFF
  a_heater_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.heater_enable) |-> (out_item_o.mode == trpc_pkg::MODE_RUN))
    else $error("heater enabled outside running mode");

  a_duty_zero_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.heater_enable) |-> (out_item_o.heater_duty == '0))
    else $error("nonzero duty with heater disabled");

  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DUTY_W'(DUTY_MAX))
    else $error("duty above saturation limit");
`endif

endmodule

`default_nettype wire

// ===== src/trpc_ctrl.sv =====
`default_nettype none

// Mode machine and PID state. Computes error, clamped integral and derivative
// for the item in the input register and commits the new state when the item
// moves on.
module trpc_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              commit_i,
  input  wire trpc_pkg::in_item_t                item_i,
  input  wire logic [trpc_pkg::LIMIT_W-1:0]      integ_limit_i,
  output trpc_pkg::pid_t                         pid_o
);

  trpc_pkg::mode_e                          mode_q, mode_d;
  logic [trpc_pkg::TGT_W-1:0]               tgt_now_q, tgt_now_d;
  logic [trpc_pkg::TGT_W-1:0]               tgt_before_q, tgt_before_d;
  logic signed [trpc_pkg::INTEG_W-1:0]      integ_q, integ_d;
  logic signed [trpc_pkg::ERR_W-1:0]        err_before_q, err_before_d;
  logic                                     pwm_q, pwm_d;
  logic                                     fan_q, fan_d;
  logic                                     fault_q, fault_d;
  trpc_pkg::pid_t                           pid_q, pid_d;
  trpc_pkg::duty_act_e                      act;
  logic                                     do_pid;

  // PID datapath
  logic                                     tgt_chg;
  logic [trpc_pkg::TGT_W-1:0]               tgt_eff, before_eff;
  logic signed [trpc_pkg::INTEG_W-1:0]      integ_base, integ_raw, integ_clamp, lim;
  logic signed [trpc_pkg::ERR_W-1:0]        eb, err;
  logic signed [trpc_pkg::DERIV_W-1:0]      deriv;
  logic                                     fan_pid;

  always_comb begin
    tgt_chg    = (item_i.opcode == trpc_pkg::OP_RUN) && (tgt_now_q != item_i.target_temp);
    tgt_eff    = tgt_chg ? item_i.target_temp : tgt_now_q;
    before_eff = tgt_chg ? tgt_now_q : tgt_before_q;
    integ_base = tgt_chg ? '0 : integ_q;
    eb         = tgt_chg ? '0 : err_before_q;
    err        = $signed({1'b0, tgt_eff, 4'b0000}) - $signed({1'b0, item_i.measured_temp});
    if (before_eff > tgt_eff) begin
      fan_pid = 1'b1;
    end else begin
      fan_pid = (err <= trpc_pkg::FAN_ERR_LIMIT) && (tgt_eff != before_eff);
    end
    lim       = $signed({2'b00, integ_limit_i});
    integ_raw = $signed({{(trpc_pkg::INTEG_W - trpc_pkg::ERR_W){err[trpc_pkg::ERR_W-1]}}, err})
                + integ_base;
    if (integ_raw > lim) begin
      integ_clamp = lim;
    end else if (integ_raw < -lim) begin
      integ_clamp = -lim;
    end else begin
      integ_clamp = integ_raw;
    end
    deriv = $signed({err[trpc_pkg::ERR_W-1], err}) - $signed({eb[trpc_pkg::ERR_W-1], eb});
  end

  // Next mode
  always_comb begin
    mode_d = mode_q;
    case (item_i.opcode)
      trpc_pkg::OP_RUN: begin
        if (mode_q == trpc_pkg::MODE_READY) mode_d = trpc_pkg::MODE_RUN;
      end
      trpc_pkg::OP_STOP: begin
        if (mode_q == trpc_pkg::MODE_RUN) mode_d = trpc_pkg::MODE_READY;
      end
      trpc_pkg::OP_FAN_ON: begin
        if (mode_q == trpc_pkg::MODE_READY) mode_d = trpc_pkg::MODE_FAN;
      end
      trpc_pkg::OP_FAN_OFF: begin
        if (mode_q == trpc_pkg::MODE_FAN) mode_d = trpc_pkg::MODE_READY;
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  // Outputs and the remaining state
  always_comb begin
    tgt_now_d    = tgt_now_q;
    tgt_before_d = tgt_before_q;
    integ_d      = integ_q;
    err_before_d = err_before_q;
    pwm_d        = pwm_q;
    fan_d        = fan_q;
    fault_d      = fault_q;
    act          = trpc_pkg::DUTY_HOLD;
    do_pid       = 1'b0;
    case (item_i.opcode)
      trpc_pkg::OP_POLL: begin
        do_pid = (mode_q == trpc_pkg::MODE_RUN);
      end
      trpc_pkg::OP_RUN: begin
        if (mode_q == trpc_pkg::MODE_READY) begin
          pwm_d        = 1'b1;
          act          = trpc_pkg::DUTY_ZERO;
          integ_d      = '0;
          err_before_d = '0;
          tgt_now_d    = trpc_pkg::TARGET_RST;
          tgt_before_d = trpc_pkg::TARGET_RST;
        end else if (mode_q == trpc_pkg::MODE_RUN) begin
          do_pid = 1'b1;
        end else begin
          fault_d = 1'b1;
        end
      end
      trpc_pkg::OP_STOP: begin
        if (mode_q == trpc_pkg::MODE_RUN) begin
          pwm_d = 1'b0;
          fan_d = 1'b0;
          act   = trpc_pkg::DUTY_ZERO;
        end else begin
          fault_d = 1'b1;
        end
      end
      trpc_pkg::OP_FAN_ON: begin
        if (mode_q == trpc_pkg::MODE_READY) begin
          fan_d = 1'b1;
        end else if (mode_q != trpc_pkg::MODE_FAN) begin
          fault_d = 1'b1;
        end
      end
      trpc_pkg::OP_FAN_OFF: begin
        if (mode_q == trpc_pkg::MODE_FAN) begin
          fan_d = 1'b0;
        end else begin
          fault_d = 1'b1;
        end
      end
      default: begin
        act = trpc_pkg::DUTY_HOLD;
      end
    endcase
    if (do_pid) begin
      tgt_now_d    = tgt_eff;
      tgt_before_d = before_eff;
      integ_d      = integ_clamp;
      err_before_d = err;
      fan_d        = fan_pid;
      act          = trpc_pkg::DUTY_PID;
    end
    pid_d.st.mode  = mode_d;
    pid_d.st.pwm   = pwm_d;
    pid_d.st.fan   = fan_d;
    pid_d.st.fault = fault_d;
    pid_d.act      = act;
    pid_d.err      = err;
    pid_d.integ    = integ_clamp;
    pid_d.deriv    = deriv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= trpc_pkg::MODE_READY;
      tgt_now_q    <= trpc_pkg::TARGET_RST;
      tgt_before_q <= trpc_pkg::TARGET_RST;
      integ_q      <= '0;
      err_before_q <= '0;
      pwm_q        <= 1'b0;
      fan_q        <= 1'b0;
      fault_q      <= 1'b0;
    end else if (commit_i) begin
      mode_q       <= mode_d;
      tgt_now_q    <= tgt_now_d;
      tgt_before_q <= tgt_before_d;
      integ_q      <= integ_d;
      err_before_q <= err_before_d;
      pwm_q        <= pwm_d;
      fan_q        <= fan_d;
      fault_q      <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      pid_q <= pid_d;
    end
  end

  assign pid_o = pid_q;

`ifndef ASSERT_OFF
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |=> fault_q)
    else $error("fault flag cleared");

  a_ready_fan_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == trpc_pkg::MODE_READY) |-> !fan_q && !pwm_q)
    else $error("fan or heater active in ready mode");

  a_fan_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == trpc_pkg::MODE_FAN) |-> fan_q && !pwm_q)
    else $error("fan-only mode with fan off or heater on");
`endif

endmodule

`default_nettype wire

// ===== src/trpc_mac.sv =====
`default_nettype none

// Gain multiplies (one register stage) followed by the three-term sum.
module trpc_mac (
  input  wire logic                                   clk_i,
  input  wire logic                                   load_mul_i,
  input  wire logic                                   load_sum_i,
  input  wire trpc_pkg::pid_t                         pid_i,
  input  wire logic signed [trpc_pkg::GAIN_W-1:0]     prop_gain_i,
  input  wire logic signed [trpc_pkg::GAIN_W-1:0]     integ_gain_i,
  input  wire logic signed [trpc_pkg::GAIN_W-1:0]     deriv_gain_i,
  output trpc_pkg::mac_t                              mac_o
);

  logic signed [trpc_pkg::PERR_W-1:0] p_err_q;
  logic signed [trpc_pkg::PINT_W-1:0] p_int_q;
  logic signed [trpc_pkg::PDER_W-1:0] p_der_q;
  trpc_pkg::status_t                  st_q;
  trpc_pkg::duty_act_e                act_q;
  trpc_pkg::mac_t                     mac_q, mac_d;

  // Both operands are sign-extended to the full product width first.
  always_ff @(posedge clk_i) begin
    if (load_mul_i) begin
      p_err_q <= trpc_pkg::PERR_W'(prop_gain_i) * trpc_pkg::PERR_W'(pid_i.err);
      p_int_q <= trpc_pkg::PINT_W'(integ_gain_i) * trpc_pkg::PINT_W'(pid_i.integ);
      p_der_q <= trpc_pkg::PDER_W'(deriv_gain_i) * trpc_pkg::PDER_W'(pid_i.deriv);
      st_q    <= pid_i.st;
      act_q   <= pid_i.act;
    end
  end

  always_comb begin
    mac_d.st  = st_q;
    mac_d.act = act_q;
    mac_d.sum = trpc_pkg::SUM_W'(p_err_q) + trpc_pkg::SUM_W'(p_int_q)
                + trpc_pkg::SUM_W'(p_der_q);
  end

  always_ff @(posedge clk_i) begin
    if (load_sum_i) begin
      mac_q <= mac_d;
    end
  end

  assign mac_o = mac_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import trpc_pkg::*;

  // Duty ceiling of the controller under test; the instance uses the same value.
  localparam int unsigned DUTY_LIMIT   = 1023;
  // Measured temperatures and errors are kept in 1/16 degree units.
  localparam int          TEMP_SCALE   = 16;
  localparam int          TGT_MAX      = (1 << TGT_W) - 1;
  localparam int          MEAS_MAX     = (1 << MEAS_W) - 1;
  // Opcodes 5 to 7 have no function and must leave every register alone.
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  // Wait after the last result that is enough for the controller to go fully quiet.
  localparam int unsigned SETTLE_CYCLES = 12;
  // Length of the long output hold used to back the pipeline up to its input.
  localparam int unsigned LONG_HOLD     = 200;
  // Far above the slowest legal run, including long holds and all gaps.
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // Scoreboard: a cycle-free copy of the controller that predicts the status
  // word for every accepted item and checks results in order.
  class pid_scoreboard;
    logic signed [GAIN_W-1:0]  kp, ki, kd;
    logic [LIMIT_W-1:0]        integ_lim;
    mode_e                     run_mode;
    logic [TGT_W-1:0]          tgt_now, tgt_prev;
    logic signed [INTEG_W-1:0] integ_acc;
    logic signed [ERR_W-1:0]   err_prev;
    logic [HDUTY_W-1:0]        duty;
    logic                      pwm, fan, fault;
    out_item_t                 expected_q[$];
    int unsigned               errors, items_seen, results_seen;
    int unsigned               sat_count, clamp_count;

    function new();
      kp          = '0;
      ki          = '0;
      kd          = '0;
      integ_lim   = INTEG_LIMIT_RST;
      run_mode    = MODE_READY;
      tgt_now     = TARGET_RST;
      tgt_prev    = TARGET_RST;
      integ_acc   = '0;
      err_prev    = '0;
      duty        = '0;
      pwm         = 1'b0;
      fan         = 1'b0;
      fault       = 1'b0;
      errors      = 0;
      items_seen  = 0;
      results_seen = 0;
      sat_count   = 0;
      clamp_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        CFG_PROP_GAIN:   kp = data;
        CFG_INTEG_GAIN:  ki = data;
        CFG_DERIV_GAIN:  kd = data;
        CFG_INTEG_LIMIT: integ_lim = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // One control step. A run command with a new target restarts the integral
    // and the derivative history before the step is taken.
    function void pid_update(logic [TGT_W-1:0] tgt, logic [MEAS_W-1:0] meas, bit retarget);
      int     err, integ, deriv, lim;
      longint acc;
      if (retarget && tgt_now != tgt) begin
        tgt_prev  = tgt_now;
        tgt_now   = tgt;
        integ_acc = '0;
        err_prev  = '0;
      end
      err = int'(tgt_now) * TEMP_SCALE - int'(meas);
      if (tgt_prev > tgt_now) fan = 1'b1;
      else fan = (err <= int'(FAN_ERR_LIMIT)) && (tgt_now != tgt_prev);
      lim   = int'(integ_lim);
      integ = err + int'(integ_acc);
      if (integ > lim) begin
        integ = lim;
        clamp_count++;
      end else if (integ < -lim) begin
        integ = -lim;
        clamp_count++;
      end
      deriv = err - int'(err_prev);
      acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * deriv;
      if (acc < 0) begin
        duty = '0;
      end else if ((acc >>> FRAC_W) > DUTY_LIMIT) begin
        duty = HDUTY_W'(DUTY_LIMIT);
        sat_count++;
      end else begin
        duty = HDUTY_W'(acc >>> FRAC_W);
      end
      err_prev  = ERR_W'(err);
      integ_acc = INTEG_W'(integ);
    endfunction

    function void note_item(in_item_t it);
      out_item_t want;
      items_seen++;
      case (it.opcode)
        OP_POLL: begin
          if (run_mode == MODE_RUN) pid_update(it.target_temp, it.measured_temp, 1'b0);
        end
        OP_RUN: begin
          if (run_mode == MODE_READY) begin
            run_mode  = MODE_RUN;
            pwm       = 1'b1;
            duty      = '0;
            integ_acc = '0;
            err_prev  = '0;
            tgt_now   = TARGET_RST;
            tgt_prev  = TARGET_RST;
          end else if (run_mode == MODE_RUN) begin
            pid_update(it.target_temp, it.measured_temp, 1'b1);
          end else begin
            fault = 1'b1;
          end
        end
        OP_STOP: begin
          if (run_mode == MODE_RUN) begin
            run_mode = MODE_READY;
            pwm      = 1'b0;
            duty     = '0;
            fan      = 1'b0;
          end else begin
            fault = 1'b1;
          end
        end
        OP_FAN_ON: begin
          if (run_mode == MODE_READY) begin
            run_mode = MODE_FAN;
            fan      = 1'b1;
          end else if (run_mode != MODE_FAN) begin
            fault = 1'b1;
          end
        end
        OP_FAN_OFF: begin
          if (run_mode == MODE_FAN) begin
            run_mode = MODE_READY;
            fan      = 1'b0;
          end else begin
            fault = 1'b1;
          end
        end
        default: ;
      endcase
      want.mode          = run_mode;
      want.heater_duty   = duty;
      want.heater_enable = pwm;
      want.fan_drive     = fan;
      want.fault_flag    = fault;
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s is %0d, predicted %0d", results_seen, name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d (%h) arrived with no item pending", results_seen, got));
        return;
      end
      want = expected_q.pop_front();
      if ($isunknown(got))
        report($sformatf("result %0d has unknown bits: %h", results_seen, got));
      compare_field("mode", got.mode, want.mode);
      compare_field("heater_duty", got.heater_duty, want.heater_duty);
      compare_field("heater_enable", got.heater_enable, want.heater_enable);
      compare_field("fan_drive", got.fan_drive, want.fan_drive);
      compare_field("fault_flag", got.fault_flag, want.fault_flag);
    endtask
  endclass

  // All inputs of the controller hold a known value from time zero.
  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data  = '0;

  pid_scoreboard sb = new();

  // Shared knobs between the stimulus thread and the output sink.
  bit                   idle_on       = 1'b1;
  bit                   long_hold_req = 1'b0;
  logic [TGT_W-1:0]     last_target   = TARGET_RST;
  int unsigned          settings_used = 0;
  int unsigned          cycle_count   = 0;

  thermal_pid_run_controller #(
    .DUTY_MAX(DUTY_LIMIT)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog. Any hang, such as a lost result that the drain waits on forever,
  // ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Results are sampled at the rising edge, where the stall we drove at the
  // previous falling edge is stable, and checked in order.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Output sink. It stalls in short random bursts while idling is enabled and
  // holds off for a long stretch on request, so that the pipeline fills and
  // the controller has to stall its own input.
  initial begin : result_sink
    int unsigned burst;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int unsigned pick_gap();
    if (!idle_on || $urandom_range(0, 4) != 0) return 0;
    return $urandom_range(1, 10);
  endfunction

  // Offers one item, optionally after a gap, and notes it once accepted. Valid
  // stays high from one item to the next when there is no gap, so each signal
  // gets a single update per falling edge.
  task automatic send_item(in_item_t it, int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic send_cmd(logic [OP_W-1:0] op, logic [TGT_W-1:0] tgt, logic [MEAS_W-1:0] meas);
    in_item_t it;
    it.opcode        = op;
    it.target_temp   = tgt;
    it.measured_temp = meas;
    send_item(it, pick_gap());
  endtask

  // Lowers valid and waits until every predicted result has been seen, then
  // lets the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers are only rewritten with the controller idle.
  task automatic program_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                               logic [GAIN_W-1:0] d, logic [GAIN_W-1:0] lim);
    drain();
    write_reg(CFG_PROP_GAIN, p);
    write_reg(CFG_INTEG_GAIN, i);
    write_reg(CFG_DERIV_GAIN, d);
    write_reg(CFG_INTEG_LIMIT, lim);
    settings_used++;
  endtask

  // Signed Q16.16 gain in the range of plus or minus span whole units.
  function automatic logic [GAIN_W-1:0] rand_gain(int unsigned span);
    return GAIN_W'(int'($urandom_range(0, 2 * span * 65536)) - int'(span * 65536));
  endfunction

  // Random items lean toward runs and polls with a steady target and a
  // measurement close to it, so the loop spends long stretches regulating.
  // The remainder restarts the session, toggles the fan or sends spare codes.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int          m;
    pick = $urandom_range(0, 99);
    if (pick < 40)      it.opcode = OP_POLL;
    else if (pick < 75) it.opcode = OP_RUN;
    else if (pick < 82) it.opcode = OP_STOP;
    else if (pick < 88) it.opcode = OP_FAN_ON;
    else if (pick < 94) it.opcode = OP_FAN_OFF;
    else it.opcode = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    if ($urandom_range(0, 3) == 0) last_target = TGT_W'($urandom_range(0, TGT_MAX));
    it.target_temp = last_target;
    if ($urandom_range(0, 4) == 0) begin
      it.measured_temp = MEAS_W'($urandom_range(0, MEAS_MAX));
    end else begin
      m = int'(last_target) * TEMP_SCALE + int'($urandom_range(0, 320)) - 160;
      if (m < 0) m = 0;
      if (m > MEAS_MAX) m = MEAS_MAX;
      it.measured_temp = MEAS_W'(m);
    end
    return it;
  endfunction

  // Idling is redrawn every 40 items, which leaves stretches without any gaps.
  task automatic run_random(int unsigned count, bit allow_idle);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      send_item(random_item(), pick_gap());
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Moderate gains (20, 0.5 and 5 counts per degree) and a narrow clamp so
    // that the directed items reach both saturation points and the clamp.
    program_gains(32'h0014_0000, 32'h0000_8000, 32'h0005_0000, 32'd2000);

    // Mode machine walk-through with only legal commands first, since the
    // fault flag never clears once set.
    send_cmd(OP_POLL, 8'd0, 12'd0);            // poll while ready does nothing
    send_cmd(OP_SPARE_FIRST, 8'd255, 12'd4095);
    send_cmd(OP_FAN_ON, 8'd0, 12'd0);           // ready to fan-only
    send_cmd(OP_FAN_ON, 8'd0, 12'd0);           // fan on again is harmless
    send_cmd(OP_POLL, 8'd90, 12'd100);          // no loop step in fan-only mode
    send_cmd(OP_FAN_OFF, 8'd0, 12'd0);
    send_cmd(OP_RUN, 8'd200, 12'd0);            // start: targets back to 25
    send_cmd(OP_POLL, 8'd200, 12'd0);
    send_cmd(OP_RUN, 8'd25, 12'd4095);          // same target, error negative
    send_cmd(OP_RUN, 8'd255, 12'd0);            // largest error, duty pegs high
    send_cmd(OP_RUN, 8'd0, 12'd4095);           // falling target turns the fan on
    send_cmd(OP_POLL, 8'd0, 12'd4095);          // integral runs into its clamp
    send_cmd(OP_RUN, 8'd100, 12'd1000);         // rising target, fan off
    send_cmd(OP_RUN, 8'd100, 12'd1700);         // 6.25 degrees too hot: fan on
    send_cmd(OP_POLL, 8'd100, 12'd1615);        // just under the fan threshold
    send_cmd(OP_POLL, 8'd100, 12'd1616);        // exactly on it
    send_cmd(OP_SPARE_LAST, 8'd0, 12'd0);
    send_cmd(OP_STOP, 8'd0, 12'd0);             // running back to ready
    // Now each illegal command in turn.
    send_cmd(OP_FAN_OFF, 8'd0, 12'd0);          // fan off while ready
    send_cmd(OP_STOP, 8'd0, 12'd0);             // stop while ready
    send_cmd(OP_RUN, 8'd40, 12'd640);
    send_cmd(OP_FAN_ON, 8'd40, 12'd640);        // fan on while running
    send_cmd(OP_FAN_OFF, 8'd40, 12'd640);       // fan off while running
    send_cmd(OP_STOP, 8'd0, 12'd0);
    send_cmd(OP_FAN_ON, 8'd0, 12'd0);
    send_cmd(OP_RUN, 8'd60, 12'd0);             // run while fan-only
    send_cmd(OP_STOP, 8'd0, 12'd0);             // stop while fan-only
    send_cmd(OP_FAN_OFF, 8'd0, 12'd0);
    run_random(220, 1'b1);

    // Extreme gains and the widest clamp. The sink holds off for a long time
    // while items keep coming, which backs the pipeline up to its input.
    program_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h000F_FFFF);
    long_hold_req = 1'b1;
    run_random(250, 1'b1);

    // All gains zero and a zero clamp: the duty must stay at zero.
    program_gains(32'h0, 32'h0, 32'h0, 32'h0);
    run_random(200, 1'b1);

    // Negative proportional gain with the most negative derivative gain and
    // the reset clamp. Halfway through the sender waits for every result.
    program_gains(32'hFFFD_0000, 32'h0000_4000, 32'h8000_0000, 32'(INTEG_LIMIT_RST));
    run_random(120, 1'b1);
    drain();
    run_random(120, 1'b1);

    // Random gains of useful size and another long output hold.
    program_gains(rand_gain(64), rand_gain(64), rand_gain(64), 32'($urandom_range(0, 4000)));
    long_hold_req = 1'b1;
    run_random(250, 1'b1);

    // Fully random register contents; the limit write also carries junk in
    // the bits above the clamp field.
    program_gains($urandom(), $urandom(), $urandom(), $urandom());
    run_random(250, 1'b1);

    // Gentle gains and a small clamp, with both sides running flat out.
    program_gains(32'h0001_0000, 32'h0000_0400, 32'h0, 32'd100);
    run_random(250, 1'b0);

    drain();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.expected_q.size()));

    $display("Checked %0d results for %0d items over %0d register settings.",
             sb.results_seen, sb.items_seen, settings_used);
    $display("The duty clipped at its ceiling %0d times; the integral was clamped %0d times.",
             sb.sat_count, sb.clamp_count);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/trpc_pkg.sv
src/trpc_ctrl.sv
src/trpc_mac.sv
src/thermal_pid_run_controller.sv
test/testbench.sv
